>>> design/scd_pkg.sv
// Shared types and constants for the sector cache directory.
// No dependencies; compiled first.
package scd_pkg;

	// Default number of directory entries
	localparam int unsigned DIR_ENTRIES = 64;

	// Field widths
	localparam int unsigned TAG_W   = 32;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned STAT_W  = 2;

	// Command codes carried on the request channel
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_STORE  = 1'b1;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// Directory control states
	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

endpackage

>>> design/scd_if.sv
// Request and response channel interfaces of the sector cache directory.
// Depends on scd_pkg for field widths.
interface scd_req_if import scd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [TAG_W-1:0] sector_addr;

	modport source (output valid, cmd, sector_addr, input ready);
	modport sink   (input valid, cmd, sector_addr, output ready);
endinterface

interface scd_rsp_if import scd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  entry_index;

	modport source (output valid, status, entry_index, input ready);
	modport sink   (input valid, status, entry_index, output ready);
endinterface

>>> design/scd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/sector_cache_directory_fifo_top.sv
// Sector cache directory top: tag RAM scan with round-robin replacement.
// An out-of-range address or no device is rejected without a scan, with the result registered
// in the cycle after the request transfer; a lookup or store otherwise scans the valid entries
// (at most ENTRIES) in order, stopping at a hit, and an empty directory needs no scan.
// One request at a time; a new request is taken only when the result register is empty or
// transfers in that cycle. Reset clears the fill count and victim pointer (no clearing pass).
module sector_cache_directory_fifo_top import scd_pkg::*; #(
	parameter int unsigned ENTRIES = DIR_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TAG_W-1:0] cfg_wdata,
	scd_req_if.sink          req,
	scd_rsp_if.source        rsp
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// Control state
	state_t           state_q, state_d;
	logic [TAG_W-1:0] limit_q;
	logic [CW-1:0]    fill_q;
	logic [IW-1:0]    victim_q;
	logic [CW-1:0]    idx_q;
	logic             cmp_vld_s1;
	logic             out_vld_q;

	// Payload registers
	logic             cmd_q;
	logic [TAG_W-1:0] addr_q;
	logic [IW-1:0]    cmp_idx_s1;
	status_t          out_status_q;
	logic [IDX_W-1:0] out_idx_q;

	// Tag RAM signals
	logic [TAG_W-1:0] tag_rdata;
	logic             issue;
	logic             fill_wr;

	// Datapath control
	logic             accept;
	logic             more;
	logic             hit;
	logic             load;
	status_t          ld_status;
	logic [IW-1:0]    ld_idx;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);

	// Valid entries are exactly those below the fill count
	assign more  = (idx_q < fill_q);
	assign hit   = cmp_vld_s1 && (tag_rdata == addr_q);
	assign issue = (state_q == S_SCAN) && more && !hit;

	scd_ram #(
		.WIDTH (TAG_W),
		.DEPTH (ENTRIES)
	) u_tag_ram (
		.clk   (clk),
		.we    (fill_wr),
		.waddr (victim_q),
		.wdata (addr_q),
		.re    (issue),
		.raddr (idx_q[IW-1:0]),
		.rdata (tag_rdata)
	);

	// Next state and result selection
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		ld_status = ST_OK;
		ld_idx    = '0;
		fill_wr   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.sector_addr >= limit_q) begin
						load      = 1'b1;
						ld_status = ST_BAD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					load    = 1'b1;
					ld_idx  = cmp_idx_s1;
					state_d = S_IDLE;
				end else if (!cmp_vld_s1 && !more) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (cmd_q == CMD_STORE) begin
						fill_wr = 1'b1;
						ld_idx  = victim_q;
					end else begin
						ld_status = ST_MISS;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= '0;
			fill_q     <= '0;
			victim_q   <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			// New tag goes to the victim entry
			if (fill_wr) begin
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + 1'b1;
				end
				victim_q <= (victim_q == LAST_IDX) ? '0 : victim_q + 1'b1;
			end
			// Binding a device empties the directory
			if (cfg_we) begin
				limit_q <= cfg_wdata;
				if (cfg_wdata != '0) begin
					fill_q   <= '0;
					victim_q <= '0;
				end
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			addr_q <= req.sector_addr;
		end
		if (issue) begin
			cmp_idx_s1 <= idx_q[IW-1:0];
		end
		if (load) begin
			out_status_q <= ld_status;
			out_idx_q    <= IDX_W'(ld_idx);
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_index = out_idx_q;

	// Fill count never passes the directory size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond directory size");

	// Until the directory is full, the victim pointer tracks the fill count
	a_victim_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FULL_CNT) |-> (CW'(victim_q) == fill_q))
		else $error("victim pointer out of step with fill count");

	// Only valid entries are compared
	a_cmp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (CW'(cmp_idx_s1) < fill_q))
		else $error("compare on an entry that is not valid");

	// The result register is free for the whole scan
	a_scan_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !out_vld_q)
		else $error("result pending during scan");

	// A non-OK result carries entry zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_status_q != ST_OK)) |-> (out_idx_q == '0))
		else $error("entry index set on a failed request");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sector cache directory (fully associative, round-robin).
// Depends on scd_pkg, scd_req_if/scd_rsp_if and sector_cache_directory_fifo_top.
// A queue-fed driver, a monitor and an in-bench directory predictor check every response.
module testbench import scd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RUN_LIMIT   = 1_000_000;
	localparam int unsigned IDLE_PCT    = 22;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned POOL_MAX    = 96;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 168;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct {
		logic             cmd;
		logic [TAG_W-1:0] addr;
	} sector_req_t;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] entry;
	} dir_rsp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [TAG_W-1:0] cfg_wdata;

	scd_req_if req_ch();
	scd_rsp_if rsp_ch();

	sector_cache_directory_fifo_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predicted directory contents
	logic [TAG_W-1:0] dir_tag [DIR_ENTRIES];
	logic             dir_valid [DIR_ENTRIES];
	logic [IDX_W-1:0] dir_victim;
	logic [TAG_W-1:0] dev_sectors;

	sector_req_t      pending_req_q[$];
	dir_rsp_t         expected_rsp_q[$];
	logic [TAG_W-1:0] addr_pool [POOL_MAX];

	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;
	logic        steady;

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Directory lookup/store as the block should perform it
	function automatic dir_rsp_t dir_access(input logic cmd, input logic [TAG_W-1:0] addr);
		dir_rsp_t res;
		int       hit;
		int       k;
		res.status = ST_BAD;
		res.entry  = '0;
		hit        = -1;
		if (dev_sectors != '0 && addr < dev_sectors) begin
			for (k = 0; k < DIR_ENTRIES; k++) begin
				if (hit < 0 && dir_valid[k] && dir_tag[k] == addr)
					hit = k;
			end
			if (hit >= 0) begin
				res.status = ST_OK;
				res.entry  = IDX_W'(hit);
			end else if (cmd == CMD_STORE) begin
				// take the victim entry, pointer wraps at the directory size
				dir_tag[dir_victim]   = addr;
				dir_valid[dir_victim] = 1'b1;
				res.status            = ST_OK;
				res.entry             = dir_victim;
				dir_victim            = dir_victim + 1'b1;
			end else begin
				res.status = ST_MISS;
			end
		end
		return res;
	endfunction

	// Sector address for random traffic: mostly a reused working set
	function automatic logic [TAG_W-1:0] pick_sector(input logic [TAG_W-1:0] limit,
			input int unsigned pool_n);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 75)
			return addr_pool[$urandom_range(pool_n - 1, 0)];
		if (roll < 85)
			return (limit == '0) ? $urandom : $urandom_range(limit - 1, 0);
		if (roll < 93) begin
			case ($urandom_range(3, 0))
				0: return limit - 1;
				1: return limit;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic push_req(input logic cmd, input logic [TAG_W-1:0] addr);
		sector_req_t item;
		item.cmd  = cmd;
		item.addr = addr;
		pending_req_q.push_back(item);
	endtask

	// Block until every queued transfer has gone out and every response came back
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_req_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
	endtask

	// Register write while the directory is idle
	task automatic set_sector_limit(input logic [TAG_W-1:0] value);
		int k;
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dev_sectors = value;
		// binding a device flushes the directory; unbinding leaves it alone
		if (value != '0) begin
			for (k = 0; k < DIR_ENTRIES; k++)
				dir_valid[k] = 1'b0;
			dir_victim = '0;
		end
	endtask

	// Request driver: pops pending items, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		sector_req_t item;
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.cmd         <= CMD_LOOKUP;
			req_ch.sector_addr <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_rsp_q.push_back(dir_access(req_ch.cmd, req_ch.sector_addr));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_req_q.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
					item = pending_req_q.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.cmd         <= item.cmd;
					req_ch.sector_addr <= item.addr;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: random stalls plus an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    = 0;
			holds_served = 0;
		end else if (hold_left > 0) begin
			hold_left    = hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served = holds_served + 1;
			hold_left    = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Response monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		dir_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected response: status %0d entry %0d",
						rsp_ch.status, rsp_ch.entry_index);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.entry_index !== want.entry) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("response mismatch: status exp %0d got %0d, entry exp %0d got %0d",
							want.status, rsp_ch.status, want.entry, rsp_ch.entry_index);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		logic [TAG_W-1:0] phase_limit [PHASES];
		logic [TAG_W-1:0] limit;
		int unsigned      pool_n;
		int               k;
		int               p;
		int               n;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_LOOKUP;
		req_ch.sector_addr = '0;
		rsp_ch.ready       = 1'b0;
		mismatch_count     = 0;
		cycle_count        = 0;
		hold_requests      = 0;
		steady             = 1'b0;
		dev_sectors        = '0;
		dir_victim         = '0;
		for (k = 0; k < DIR_ENTRIES; k++) begin
			dir_tag[k]   = '0;
			dir_valid[k] = 1'b0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// no device bound out of reset
		push_req(CMD_LOOKUP, 32'd0);
		push_req(CMD_STORE, 32'd5);
		push_req(CMD_STORE, 32'hFFFF_FFFF);

		// widest device: edges of the address range, reuse, both bit patterns
		set_sector_limit(32'hFFFF_FFFF);
		push_req(CMD_STORE, 32'd0);
		push_req(CMD_STORE, 32'hFFFF_FFFE);
		push_req(CMD_LOOKUP, 32'hFFFF_FFFE);
		push_req(CMD_LOOKUP, 32'd0);
		push_req(CMD_LOOKUP, 32'hFFFF_FFFF);
		push_req(CMD_STORE, 32'hFFFF_FFFF);
		push_req(CMD_LOOKUP, 32'd12345);
		push_req(CMD_STORE, 32'd0);
		push_req(CMD_STORE, 32'h5555_5555);
		push_req(CMD_STORE, 32'hAAAA_AAAA);
		push_req(CMD_LOOKUP, 32'hAAAA_AAAA);

		// unbind: everything rejected
		set_sector_limit(32'd0);
		push_req(CMD_LOOKUP, 32'd0);
		push_req(CMD_STORE, 32'd0);

		// rebind flushes the directory
		set_sector_limit(32'd3);
		push_req(CMD_LOOKUP, 32'd0);
		push_req(CMD_STORE, 32'd2);
		push_req(CMD_STORE, 32'd3);
		push_req(CMD_LOOKUP, 32'd2);

		phase_limit[0] = 32'hFFFF_FFFF;
		phase_limit[1] = 32'd1;
		phase_limit[2] = 32'd2;
		phase_limit[3] = 32'd0;
		phase_limit[4] = 32'd64;
		phase_limit[5] = 32'd1000;
		phase_limit[6] = 32'h8000_0000;
		phase_limit[7] = $urandom_range(4000, 70);
		phase_limit[8] = $urandom | 32'h1;
		phase_limit[9] = 32'hFFFF_FFFF;

		// random phases, one device size each
		for (p = 0; p < PHASES; p++) begin
			limit = phase_limit[p];
			set_sector_limit(limit);
			steady = (p == 5);
			if (p == 1 || p == 7)
				hold_requests = hold_requests + 1;
			// working set sometimes fits, sometimes forces replacement
			pool_n = $urandom_range(POOL_MAX, 16);
			for (k = 0; k < POOL_MAX; k++)
				addr_pool[k] = (limit == '0) ? $urandom : $urandom_range(limit - 1, 0);
			addr_pool[0] = limit - 1;
			for (n = 0; n < PHASE_ITEMS; n++)
				push_req(($urandom_range(99, 0) < 45) ? CMD_STORE : CMD_LOOKUP,
					pick_sector(limit, pool_n));
		end

		wait_idle();
		repeat (DIR_ENTRIES + 16) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sector_cache_directory_fifo_top.f
design/scd_pkg.sv
design/scd_if.sv
design/scd_ram.sv
design/sector_cache_directory_fifo_top.sv
tb/sv/testbench.sv
